[src/drc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drc_pkg
// Types, codes and rectangle helpers for the dirty rectangle coalescer.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_AREA = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [2:0] REG_X_OFF  = 3'd0;
    localparam logic [2:0] REG_Y_OFF  = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_MAPPED = 3'd4;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = 5;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
    } req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] area_x;
        logic signed [15:0] area_y;
        logic [15:0]        area_w;
        logic [15:0]        area_h;
        logic               last;
        logic               overflow;
        logic [4:0]         stored_count;
    } rsp_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        w;
        logic [16:0]        h;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARD,
        ST_ACHK,
        ST_AMOVE,
        ST_APASS,
        ST_CRD,
        ST_CABS,
        ST_AWR,
        ST_FRD,
        ST_FCHK,
        ST_FPUSH,
        ST_FDONE
    } state_t;

    function automatic logic signed [17:0] sx18(logic signed [15:0] v);
        return {{2{v[15]}}, v};
    endfunction

    function automatic logic signed [17:0] zx18(logic [16:0] v);
        return {1'b0, v};
    endfunction

    function automatic logic touches(entry_t a, entry_t b);
        logic signed [17:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        ax0 = sx18(a.x);
        ay0 = sx18(a.y);
        ax1 = ax0 + zx18(a.w);
        ay1 = ay0 + zx18(a.h);
        bx0 = sx18(b.x);
        by0 = sx18(b.y);
        bx1 = bx0 + zx18(b.w);
        by1 = by0 + zx18(b.h);
        return (ax0 <= bx1) && (ay0 <= by1) && (ax1 >= bx0) && (ay1 >= by0);
    endfunction

    function automatic entry_t absorb(entry_t a, entry_t b);
        logic signed [17:0] ax1, ay1, bx1, by1, x1, y1, x0, y0, dw, dh;
        entry_t r;
        ax1 = sx18(a.x) + zx18(a.w);
        ay1 = sx18(a.y) + zx18(a.h);
        bx1 = sx18(b.x) + zx18(b.w);
        by1 = sx18(b.y) + zx18(b.h);
        x1 = (ax1 > bx1) ? ax1 : bx1;
        y1 = (ay1 > by1) ? ay1 : by1;
        r.x = (a.x < b.x) ? a.x : b.x;
        r.y = (a.y < b.y) ? a.y : b.y;
        x0 = sx18(r.x);
        y0 = sx18(r.y);
        dw = x1 - x0;
        dh = y1 - y0;
        r.w = dw[16:0];
        r.h = dh[16:0];
        return r;
    endfunction

    function automatic logic [15:0] sat16(logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

endpackage
`default_nettype wire

[src/drc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module drc_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/dirty_rect_coalescer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dirty_rect_coalescer_core
// Damage rectangle table with merge on add and clipped drain on flush.
// ----------------------------------------------------------------------------
// Requests come in on req (valid/stall), results leave on rsp (valid/stall).
// A transfer on req is taken only while the block is idle; one request is
// worked on at a time. Window registers sit on the APB port (pready always
// high); the user must write them between requests; the block won't check.
// On add, the table RAM is rescanned pass by pass; each touching entry is
// absorbed into the new area and replaced by the last one, until a pass
// absorbs nothing; a full table is then collapsed into the area, overflow
// set. One result per add, with the merged area and the entry count.
// On flush, entries are read in table order and clipped to the window; those
// with area left leave as results, at most MAX_RESULTS, the final one
// carries last (a none result if nothing is left or the window is unmapped).
// Reset empties the table (entry count only) and clears the control registers.
// A stalled receiver holds the result register; the sequencer waits.
// ----------------------------------------------------------------------------
module dirty_rect_coalescer_core #(
    parameter int MAX_AREAS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire drc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output drc_pkg::rsp_t      rsp,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);

    localparam int IW = $clog2(MAX_AREAS);
    localparam int CW = $clog2(MAX_AREAS + 1);
    localparam int EW = $bits(drc_pkg::entry_t);

    drc_pkg::state_t    state_reg, state_next;
    drc_pkg::entry_t    cur_reg, cur_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               changed_reg, changed_next;
    logic               ovf_reg, ovf_next;
    logic               empty_reg, empty_next;
    drc_pkg::rsp_t      cand_reg, cand_next;
    drc_pkg::rsp_t      pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [drc_pkg::RES_W-1:0] nres_reg, nres_next;
    drc_pkg::rsp_t      out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [15:0] x_off_reg, y_off_reg;
    logic [14:0]        width_reg, height_reg;
    logic               mapped_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    drc_pkg::entry_t    ram_wdata, ram_rdata;
    logic [EW-1:0]      ram_rbits;

    logic               out_free;
    logic               req_take;
    logic               cfg_wr;
    logic [CW:0]        idx_inc;

    logic signed [18:0] cx, cy, cw, ch, rx, ry;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign req_stall = (state_reg != drc_pkg::ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign ram_rdata = drc_pkg::entry_t'(ram_rbits);
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            drc_pkg::REG_X_OFF:  prdata = {{16{x_off_reg[15]}}, x_off_reg};
            drc_pkg::REG_Y_OFF:  prdata = {{16{y_off_reg[15]}}, y_off_reg};
            drc_pkg::REG_WIDTH:  prdata = {17'd0, width_reg};
            drc_pkg::REG_HEIGHT: prdata = {17'd0, height_reg};
            drc_pkg::REG_MAPPED: prdata = {31'd0, mapped_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg  <= '0;
            y_off_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            mapped_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                drc_pkg::REG_X_OFF:  x_off_reg  <= pwdata[15:0];
                drc_pkg::REG_Y_OFF:  y_off_reg  <= pwdata[15:0];
                drc_pkg::REG_WIDTH:  width_reg  <= pwdata[14:0];
                drc_pkg::REG_HEIGHT: height_reg <= pwdata[14:0];
                drc_pkg::REG_MAPPED: mapped_reg <= pwdata[0];
                default:             ;
            endcase
        end
    end

    // clip of the entry just read against the window
    always_comb
    begin
        cx = {{3{ram_rdata.x[15]}}, ram_rdata.x};
        cy = {{3{ram_rdata.y[15]}}, ram_rdata.y};
        cw = {2'b00, ram_rdata.w};
        ch = {2'b00, ram_rdata.h};
        rx = {{3{x_off_reg[15]}}, x_off_reg} + {4'd0, width_reg};
        ry = {{3{y_off_reg[15]}}, y_off_reg} + {4'd0, height_reg};
        if (cx < $signed({{3{x_off_reg[15]}}, x_off_reg}))
        begin
            cw = cw - ({{3{x_off_reg[15]}}, x_off_reg} - cx);
            cx = {{3{x_off_reg[15]}}, x_off_reg};
        end
        if (cx + cw > rx)
        begin
            cw = rx - cx;
        end
        if (cy < $signed({{3{y_off_reg[15]}}, y_off_reg}))
        begin
            ch = ch - ({{3{y_off_reg[15]}}, y_off_reg} - cy);
            cy = {{3{y_off_reg[15]}}, y_off_reg};
        end
        if (cy + ch > ry)
        begin
            ch = ry - cy;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        changed_next    = changed_reg;
        ovf_next        = ovf_reg;
        empty_next      = empty_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        nres_next       = nres_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[IW-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[IW-1:0];

        case (state_reg)
            drc_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    cur_next.x      = req.rect_x;
                    cur_next.y      = req.rect_y;
                    cur_next.w      = {2'b00, req.rect_w};
                    cur_next.h      = {2'b00, req.rect_h};
                    idx_next        = '0;
                    changed_next    = 1'b0;
                    ovf_next        = 1'b0;
                    nres_next       = '0;
                    pend_valid_next = 1'b0;
                    if (req.opcode == drc_pkg::OP_ADD)
                    begin
                        empty_next = (req.rect_w == '0) || (req.rect_h == '0);
                        state_next = empty_next ? drc_pkg::ST_AWR : drc_pkg::ST_APASS;
                    end
                    else if (mapped_reg && (cnt_reg != '0))
                    begin
                        state_next = drc_pkg::ST_FRD;
                    end
                    else
                    begin
                        state_next = drc_pkg::ST_FDONE;
                    end
                end
            end

            drc_pkg::ST_ARD:
            begin
                state_next = drc_pkg::ST_ACHK;
            end

            drc_pkg::ST_ACHK:
            begin
                if (drc_pkg::touches(cur_reg, ram_rdata))
                begin
                    cur_next     = drc_pkg::absorb(cur_reg, ram_rdata);
                    cnt_next     = cnt_reg - 1'b1;
                    ram_raddr    = cnt_next[IW-1:0];
                    changed_next = 1'b1;
                    state_next   = drc_pkg::ST_AMOVE;
                end
                else
                begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = drc_pkg::ST_APASS;
                end
            end

            drc_pkg::ST_AMOVE:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_inc[CW-1:0];
                state_next = drc_pkg::ST_APASS;
            end

            drc_pkg::ST_APASS:
            begin
                if (idx_reg < cnt_reg)
                begin
                    state_next = drc_pkg::ST_ARD;
                end
                else if (changed_reg)
                begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                end
                else if (cnt_reg == CW'(MAX_AREAS))
                begin
                    idx_next   = '0;
                    state_next = drc_pkg::ST_CRD;
                end
                else
                begin
                    state_next = drc_pkg::ST_AWR;
                end
            end

            drc_pkg::ST_CRD:
            begin
                state_next = drc_pkg::ST_CABS;
            end

            drc_pkg::ST_CABS:
            begin
                cur_next = drc_pkg::absorb(cur_reg, ram_rdata);
                if (idx_reg == CW'(MAX_AREAS - 1))
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b1;
                    state_next = drc_pkg::ST_AWR;
                end
                else
                begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = drc_pkg::ST_CRD;
                end
            end

            drc_pkg::ST_AWR:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.kind         = drc_pkg::KIND_ADD;
                    out_next.last         = 1'b1;
                    out_next.overflow     = ovf_reg;
                    if (empty_reg)
                    begin
                        out_next.area_x       = '0;
                        out_next.area_y       = '0;
                        out_next.area_w       = '0;
                        out_next.area_h       = '0;
                        out_next.stored_count = 5'(cnt_reg);
                    end
                    else
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = cnt_reg[IW-1:0];
                        ram_wdata             = cur_reg;
                        cnt_next              = cnt_reg + 1'b1;
                        out_next.area_x       = cur_reg.x;
                        out_next.area_y       = cur_reg.y;
                        out_next.area_w       = drc_pkg::sat16(cur_reg.w);
                        out_next.area_h       = drc_pkg::sat16(cur_reg.h);
                        out_next.stored_count = 5'(cnt_next);
                    end
                    state_next = drc_pkg::ST_IDLE;
                end
            end

            drc_pkg::ST_FRD:
            begin
                state_next = drc_pkg::ST_FCHK;
            end

            drc_pkg::ST_FCHK:
            begin
                cand_next.kind         = drc_pkg::KIND_AREA;
                cand_next.area_x       = cx[15:0];
                cand_next.area_y       = cy[15:0];
                cand_next.area_w       = cw[15:0];
                cand_next.area_h       = ch[15:0];
                cand_next.last         = 1'b0;
                cand_next.overflow     = 1'b0;
                cand_next.stored_count = '0;
                if ((cw > 0) && (ch > 0))
                begin
                    state_next = drc_pkg::ST_FPUSH;
                end
                else if (idx_inc < {1'b0, cnt_reg})
                begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = drc_pkg::ST_FRD;
                end
                else
                begin
                    state_next = drc_pkg::ST_FDONE;
                end
            end

            drc_pkg::ST_FPUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                    end
                    pend_next       = cand_reg;
                    pend_valid_next = 1'b1;
                    nres_next       = nres_reg + 1'b1;
                    if ((nres_next == drc_pkg::RES_W'(drc_pkg::MAX_RESULTS))
                        || !(idx_inc < {1'b0, cnt_reg}))
                    begin
                        state_next = drc_pkg::ST_FDONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc[CW-1:0];
                        state_next = drc_pkg::ST_FRD;
                    end
                end
            end

            drc_pkg::ST_FDONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next.kind         = drc_pkg::KIND_NONE;
                        out_next.area_x       = '0;
                        out_next.area_y       = '0;
                        out_next.area_w       = '0;
                        out_next.area_h       = '0;
                        out_next.last         = 1'b1;
                        out_next.overflow     = 1'b0;
                        out_next.stored_count = '0;
                    end
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = drc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = drc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= drc_pkg::ST_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            changed_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            empty_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            nres_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            changed_reg    <= changed_next;
            ovf_reg        <= ovf_next;
            empty_reg      <= empty_next;
            pend_valid_reg <= pend_valid_next;
            nres_reg       <= nres_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    drc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_AREAS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_AREAS))
        else $error("entry count above table depth");

    a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == drc_pkg::ST_FRD || state_reg == drc_pkg::ST_FCHK
                            || state_reg == drc_pkg::ST_FPUSH
                            || state_reg == drc_pkg::ST_FDONE))
        else $error("pending area outside flush");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drc_pkg::ST_AWR && !empty_reg) |-> (cnt_reg < CW'(MAX_AREAS)))
        else $error("append into full table");
`endif

endmodule
`default_nettype wire

[tb/sv/dirty_rect_coalescer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirty_rect_coalescer_core_tb
// Self-checking bench: directed table, then random adds and flushes checked
// against a behavioral damage table; window registers set over APB.
// ----------------------------------------------------------------------------
module dirty_rect_coalescer_core_tb;

    localparam int NAREAS = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    drc_pkg::req_t req = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    drc_pkg::rsp_t rsp;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    dirty_rect_coalescer_core #(.MAX_AREAS(NAREAS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // window and damage table copy
    int     wx, wy, ww, wh;
    bit     wmap;
    int     dx[NAREAS], dy[NAREAS], dw[NAREAS], dh[NAREAS];
    int     dcount;

    drc_pkg::rsp_t pending_q[$];
    int     errors;
    int     cycles;
    bit     quiet;
    bit     hold_long;

    task automatic report(input string what, input drc_pkg::rsp_t got,
                          input drc_pkg::rsp_t want);
        errors++;
        $display("mismatch %s: got %p want %p", what, got, want);
    endtask

    function automatic drc_pkg::rsp_t mk(int kind, int x, int y, int w, int h,
                                         bit lst, bit ovf, int cnt);
        drc_pkg::rsp_t r;
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        if (w > 65535) w = 65535;
        if (h > 65535) h = 65535;
        r.kind = kind[1:0];
        r.area_x = x[15:0];
        r.area_y = y[15:0];
        r.area_w = w[15:0];
        r.area_h = h[15:0];
        r.last = lst;
        r.overflow = ovf;
        r.stored_count = cnt[4:0];
        return r;
    endfunction

    task automatic grow(inout int x, inout int y, inout int w, inout int h,
                        input int k);
        int x0, y0, x1, y1;
        x0 = (x < dx[k]) ? x : dx[k];
        y0 = (y < dy[k]) ? y : dy[k];
        x1 = (x + w > dx[k] + dw[k]) ? x + w : dx[k] + dw[k];
        y1 = (y + h > dy[k] + dh[k]) ? y + h : dy[k] + dh[k];
        x = x0; y = y0; w = x1 - x0; h = y1 - y0;
    endtask

    task automatic predict_damage(input drc_pkg::req_t r);
        int x, y, w, h, n;
        bit changed, ovf;
        x = r.rect_x; y = r.rect_y; w = r.rect_w; h = r.rect_h;
        ovf = 0;
        if (r.opcode == drc_pkg::OP_ADD)
        begin
            if (w == 0 || h == 0)
            begin
                pending_q.push_back(mk(drc_pkg::KIND_ADD, 0, 0, 0, 0, 1, 0, dcount));
                return;
            end
            do
            begin
                changed = 0;
                for (int i = 0; i < dcount; i++)
                begin
                    if (x <= dx[i] + dw[i] && y <= dy[i] + dh[i] &&
                        x + w >= dx[i] && y + h >= dy[i])
                    begin
                        changed = 1;
                        grow(x, y, w, h, i);
                        dcount--;
                        dx[i] = dx[dcount]; dy[i] = dy[dcount];
                        dw[i] = dw[dcount]; dh[i] = dh[dcount];
                    end
                end
            end while (changed);
            if (dcount >= NAREAS)
            begin
                for (int i = 0; i < NAREAS; i++) grow(x, y, w, h, i);
                dcount = 0;
                ovf = 1;
            end
            dx[dcount] = x; dy[dcount] = y; dw[dcount] = w; dh[dcount] = h;
            dcount++;
            pending_q.push_back(mk(drc_pkg::KIND_ADD, x, y, w, h, 1, ovf, dcount));
        end
        else
        begin
            n = 0;
            if (wmap)
            begin
                for (int i = 0; i < dcount && n < drc_pkg::MAX_RESULTS; i++)
                begin
                    x = dx[i]; y = dy[i]; w = dw[i]; h = dh[i];
                    if (x < wx)
                    begin
                        w -= wx - x;
                        x = wx;
                    end
                    if (x + w > wx + ww) w = wx + ww - x;
                    if (y < wy)
                    begin
                        h -= wy - y;
                        y = wy;
                    end
                    if (y + h > wy + wh) h = wy + wh - y;
                    if (w <= 0 || h <= 0) continue;
                    pending_q.push_back(mk(drc_pkg::KIND_AREA, x, y, w, h, 0, 0, 0));
                    n++;
                end
            end
            dcount = 0;
            if (n == 0)
                pending_q.push_back(mk(drc_pkg::KIND_NONE, 0, 0, 0, 0, 1, 0, 0));
            else
                pending_q[pending_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            drc_pkg::REG_X_OFF:  wx = $signed(val[15:0]);
            drc_pkg::REG_Y_OFF:  wy = $signed(val[15:0]);
            drc_pkg::REG_WIDTH:  ww = val[14:0];
            drc_pkg::REG_HEIGHT: wh = val[14:0];
            default:             wmap = val[0];
        endcase
    endtask

    task automatic set_window(input int x, input int y, input int w, input int h,
                              input bit m);
        req_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (200) @(negedge clk);
        reg_write(drc_pkg::REG_X_OFF, x);
        reg_write(drc_pkg::REG_Y_OFF, y);
        reg_write(drc_pkg::REG_WIDTH, w);
        reg_write(drc_pkg::REG_HEIGHT, h);
        reg_write(drc_pkg::REG_MAPPED, m);
    endtask

    // valid stays up after a transfer; the next call replaces the payload
    task automatic send(input drc_pkg::req_t r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict_damage(r);
        @(negedge clk);
    endtask

    function automatic drc_pkg::req_t mkreq(bit op, int x, int y, int w, int h);
        drc_pkg::req_t r;
        r.opcode = op;
        r.rect_x = x[15:0];
        r.rect_y = y[15:0];
        r.rect_w = w[14:0];
        r.rect_h = h[14:0];
        return r;
    endfunction

    function automatic drc_pkg::req_t rand_req(int span);
        int x, y;
        if ($urandom_range(0, 9) == 0)
            return mkreq(drc_pkg::OP_FLUSH, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 19) == 0)
            return mkreq(drc_pkg::OP_ADD, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 19) == 0)
            return mkreq(drc_pkg::OP_ADD, $urandom, $urandom, 0, $urandom);
        x = $signed(16'($urandom_range(0, span))) - span / 2;
        y = $signed(16'($urandom_range(0, span))) - span / 2;
        return mkreq(drc_pkg::OP_ADD, x, y, $urandom_range(1, 40), $urandom_range(1, 40));
    endfunction

    // directed rows: expected typed in where obvious, else predictor only
    typedef struct {
        drc_pkg::req_t r;
        bit            typed;
        drc_pkg::rsp_t want;
    } row_t;

    row_t rows[$];

    // receiver: random stall bursts, one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_long)
        begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clk);
            rsp_stall <= 1'b0;
            hold_long = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_q.size() == 0)
            begin
                report("unexpected transfer", rsp, '0);
            end
            else
            begin
                drc_pkg::rsp_t w;
                w = pending_q.pop_front();
                if (rsp.kind !== w.kind) report("kind", rsp, w);
                if (rsp.area_x !== w.area_x) report("area_x", rsp, w);
                if (rsp.area_y !== w.area_y) report("area_y", rsp, w);
                if (rsp.area_w !== w.area_w) report("area_w", rsp, w);
                if (rsp.area_h !== w.area_h) report("area_h", rsp, w);
                if (rsp.last !== w.last) report("last", rsp, w);
                if (rsp.overflow !== w.overflow) report("overflow", rsp, w);
                if (rsp.stored_count !== w.stored_count)
                    report("stored_count", rsp, w);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        errors = 0; cycles = 0; quiet = 0; hold_long = 0;
        wx = 0; wy = 0; ww = 0; wh = 0; wmap = 0; dcount = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rows.push_back('{mkreq(drc_pkg::OP_FLUSH, 0, 0, 0, 0), 1,
                         mk(drc_pkg::KIND_NONE, 0, 0, 0, 0, 1, 0, 0)});
        rows.push_back('{mkreq(drc_pkg::OP_ADD, 5, 5, 0, 9), 1,
                         mk(drc_pkg::KIND_ADD, 0, 0, 0, 0, 1, 0, 0)});
        rows.push_back('{mkreq(drc_pkg::OP_ADD, 5, 5, 9, 0), 1,
                         mk(drc_pkg::KIND_ADD, 0, 0, 0, 0, 1, 0, 0)});
        rows.push_back('{mkreq(drc_pkg::OP_ADD, -32768, -32768, 32767, 32767), 1,
                         mk(drc_pkg::KIND_ADD, -32768, -32768, 32767, 32767, 1, 0, 1)});
        rows.push_back('{mkreq(drc_pkg::OP_ADD, 32767, 32767, 32767, 32767), 0, '0});
        rows.push_back('{mkreq(drc_pkg::OP_ADD, 0, 0, 10, 10), 0, '0});
        rows.push_back('{mkreq(drc_pkg::OP_ADD, 10, 10, 5, 5), 0, '0});
        rows.push_back('{mkreq(drc_pkg::OP_FLUSH, -1, -1, 32767, 32767), 1,
                         mk(drc_pkg::KIND_NONE, 0, 0, 0, 0, 1, 0, 0)});
        for (int i = 0; i < 17; i++)
            rows.push_back('{mkreq(drc_pkg::OP_ADD, i * 100, 0, 10, 10), 0, '0});

        foreach (rows[i])
        begin
            send(rows[i].r);
            if (rows[i].typed && pending_q[pending_q.size() - 1] !== rows[i].want)
                report($sformatf("row %0d", i), pending_q[pending_q.size() - 1],
                       rows[i].want);
        end

        set_window(-50, -50, 32767, 32767, 1);
        for (int i = 0; i < 17; i++)
            send(mkreq(drc_pkg::OP_ADD, i * 100, i * 50, 30, 30));
        send(mkreq(drc_pkg::OP_FLUSH, 0, 0, 0, 0));
        for (int i = 0; i < 20; i++)
            send(mkreq(drc_pkg::OP_ADD, i * 60, 0, 20, 20));
        send(mkreq(drc_pkg::OP_FLUSH, 0, 0, 0, 0));

        set_window(-32768, -32768, 32767, 32767, 1);
        for (int i = 0; i < 60; i++) send(rand_req(600));

        set_window(32767, 32767, 0, 0, 1);
        for (int i = 0; i < 15; i++) send(rand_req(65535));
        send(mkreq(drc_pkg::OP_FLUSH, 0, 0, 0, 0));

        set_window(-100, -80, 150, 120, 1);
        hold_long = 1'b1;
        for (int i = 0; i < 60; i++) send(rand_req(400));

        set_window(0, 0, 32767, 32767, 0);
        for (int i = 0; i < 20; i++) send(rand_req(400));
        send(mkreq(drc_pkg::OP_FLUSH, 0, 0, 0, 0));

        set_window(-200, -200, 300, 300, 1);
        quiet = 1;
        for (int i = 0; i < 40; i++) send(rand_req(500));
        send(mkreq(drc_pkg::OP_FLUSH, 0, 0, 0, 0));
        req_valid <= 1'b0;

        wait (pending_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
src/drc_pkg.sv
src/drc_ram.sv
src/dirty_rect_coalescer_core.sv
tb/sv/dirty_rect_coalescer_core_tb.sv
